/* rtl/gcd_and_lcm_unit_defines.svh */
// Assertion macros shared by the gcd_and_lcm_unit RTL.
`ifndef GCD_AND_LCM_UNIT_DEFINES_SVH
`define GCD_AND_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GAL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gal_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gal_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int LCM_BITS     = 2 * OPERAND_BITS;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture operands
        logic div_start;  // clear remainder, load dividend and divisor
        logic div_lcm;    // divide first operand by gcd instead of a by b
        logic div_step;   // one restoring-division bit
        logic euc_upd;    // (a, b) <= (b, a mod b)
        logic mul_start;  // clear product accumulator
        logic mul_step;   // one shift-add bit
        logic out_load;   // capture result word
    } gal_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic b_zero;     // Euclid loop finished
        logic any_zero;   // an operand was zero
        logic last;       // final bit of a division or multiplication
    } gal_status_t;

endpackage

`default_nettype wire

/* rtl/gal_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "gcd_and_lcm_unit_defines.svh"

module gal_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire gal_pkg::gal_cmd_t                 cmd,
    output      gal_pkg::gal_status_t              status,
    input  wire logic [gal_pkg::OPERAND_BITS-1:0]  first_value,
    input  wire logic [gal_pkg::OPERAND_BITS-1:0]  second_value,
    output      logic [gal_pkg::OPERAND_BITS-1:0]  gcd_value,
    output      logic [gal_pkg::LCM_BITS-1:0]      lcm_value
);
    import gal_pkg::*;

    localparam int N = OPERAND_BITS;

    logic [N-1:0]        a_reg, a_next;
    logic [N-1:0]        b_reg, b_next;
    logic [N-1:0]        xs_reg, xs_next;
    logic [N-1:0]        ys_reg, ys_next;
    logic [N-1:0]        rem_reg, rem_next;
    logic [N-1:0]        quo_reg, quo_next;
    logic [N-1:0]        dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [LCM_BITS-1:0] acc_reg, acc_next;
    logic [N-1:0]        gcd_reg, gcd_next;
    logic [LCM_BITS-1:0] lcm_reg, lcm_next;

    logic [N:0]          trial;
    logic                ge;

    // restoring division trial subtract
    assign trial = {rem_reg, quo_reg[N-1]} - {1'b0, dvs_reg};
    assign ge    = ~trial[N];

    always_comb begin
        a_next   = a_reg;
        b_next   = b_reg;
        xs_next  = xs_reg;
        ys_next  = ys_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        gcd_next = gcd_reg;
        lcm_next = lcm_reg;

        if (cmd.load) begin
            a_next  = first_value;
            b_next  = second_value;
            xs_next = first_value;
            ys_next = second_value;
        end
        if (cmd.div_start) begin
            rem_next = '0;
            cnt_next = '0;
            quo_next = cmd.div_lcm ? xs_reg : a_reg;
            dvs_next = cmd.div_lcm ? a_reg : b_reg;
        end
        if (cmd.div_step) begin
            rem_next = ge ? trial[N-1:0] : {rem_reg[N-2:0], quo_reg[N-1]};
            quo_next = {quo_reg[N-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.euc_upd) begin
            a_next = b_reg;
            b_next = rem_reg;
        end
        if (cmd.mul_start) begin
            acc_next = '0;
            cnt_next = '0;
        end
        // quotient bits MSB first, multiplicand is the second operand
        if (cmd.mul_step) begin
            acc_next = {acc_reg[LCM_BITS-2:0], 1'b0}
                     + (quo_reg[N-1] ? {{(LCM_BITS-N){1'b0}}, ys_reg} : {LCM_BITS{1'b0}});
            quo_next = {quo_reg[N-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.out_load) begin
            gcd_next = a_reg;
            lcm_next = ((xs_reg != '0) && (ys_reg != '0)) ? acc_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        xs_reg  <= xs_next;
        ys_reg  <= ys_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        gcd_reg <= gcd_next;
        lcm_reg <= lcm_next;
    end

    assign status.b_zero   = (b_reg == '0);
    assign status.any_zero = (xs_reg == '0) || (ys_reg == '0);
    assign status.last     = (cnt_reg == CNT_BITS'(N - 1));

    assign gcd_value = gcd_reg;
    assign lcm_value = lcm_reg;

    `GAL_ASSERT_IMP(a_div_nonzero, aclk, aresetn, cmd.div_step, dvs_reg != '0,
        "division step with zero divisor")
    `GAL_ASSERT_IMP(a_rem_below, aclk, aresetn, cmd.div_step, rem_reg < dvs_reg,
        "partial remainder not below divisor")
    `GAL_ASSERT_IMP(a_mul_nonzero, aclk, aresetn, cmd.mul_step, ys_reg != '0,
        "multiplication started with a zero operand")

endmodule

`default_nettype wire

/* rtl/gal_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "gcd_and_lcm_unit_defines.svh"

module gal_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      gal_pkg::gal_cmd_t    cmd,
    input  wire gal_pkg::gal_status_t status
);
    import gal_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EUC  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_MULI = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       lcm_phase_reg, lcm_phase_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = ~m_valid_reg | m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // next state and command decode
    always_comb begin
        state_next     = state_reg;
        lcm_phase_next = lcm_phase_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EUC;
                end
            end
            S_EUC: begin
                if (!status.b_zero) begin
                    cmd.div_start  = 1'b1;
                    lcm_phase_next = 1'b0;
                    state_next     = S_DIV;
                end else if (status.any_zero) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div_start  = 1'b1;
                    cmd.div_lcm    = 1'b1;
                    lcm_phase_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.last) begin
                    state_next = lcm_phase_reg ? S_MULI : S_UPD;
                end
            end
            S_UPD: begin
                cmd.euc_upd = 1'b1;
                state_next  = S_EUC;
            end
            S_MULI: begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.last) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word valid flag
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            lcm_phase_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lcm_phase_reg <= lcm_phase_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    `GAL_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_valid && s_ready,
        state_reg == S_EUC, "accepted word did not start the Euclid loop")
    `GAL_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load,
        !m_valid_reg || m_ready, "result overwritten before it was taken")
    `GAL_ASSERT_NXT(a_div_ends, aclk, aresetn, (state_reg == S_DIV) && status.last,
        state_reg != S_DIV, "division ran past its last bit")

endmodule

`default_nettype wire

/* rtl/gcd_and_lcm_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// GCD and LCM unit: takes two unsigned operands per input word and returns one
// result word with their greatest common divisor and their exact least common
// multiple (zero if either operand is zero; gcd(x,0) = x). One word is worked
// at a time by a shared bit-serial divider and shift-add multiplier. Each Euclid
// remainder step is one restoring division; the LCM needs one more division of
// the first operand by the gcd and a shift-add multiply. For 31-bit operands the
// number of Euclid remainder steps is at most about 45. A finished result waits
// in an output register; the next input word is accepted while it waits.
module gcd_and_lcm_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic [gal_pkg::OPERAND_BITS-1:0]  s_first_value,
    input  wire logic [gal_pkg::OPERAND_BITS-1:0]  s_second_value,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic [gal_pkg::OPERAND_BITS-1:0]  m_gcd_value,
    output      logic [gal_pkg::LCM_BITS-1:0]      m_lcm_value
);
    import gal_pkg::*;

    gal_cmd_t    cmd;
    gal_status_t status;

    // sequencer
    gal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // operand, divider, multiplier and result registers
    gal_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .first_value  (s_first_value),
        .second_value (s_second_value),
        .gcd_value    (m_gcd_value),
        .lcm_value    (m_lcm_value)
    );

endmodule

`default_nettype wire
